>>> src/tga_rle_pixel_decoder_unit_defines.svh
// ============================================================================
// TGA RLE pixel decoder assertion macros
// Shared concurrent assertion forms for the decoder.
// ============================================================================
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tga_rle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TGA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tga_rle assertion failed");

`endif

>>> src/tga_rle_pkg.sv
// ============================================================================
// TGA RLE decoder package
// Register map, field widths, packet constants and pixel size decoding.
// ============================================================================
package tga_rle_pkg;

    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned BPP_W   = 3;
    localparam int unsigned DIM_W   = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned PIXEL_W = 32;

    localparam logic [1:0] REG_BPP    = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [BPP_W-1:0] BPP_RESET    = 3'd4;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 16'd1;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 16'd1;

    // A header below this value opens a raw packet.
    localparam logic [7:0] RUN_FLAG = 8'd128;
    // Run packets carry header minus this value copies.
    localparam logic [7:0] RUN_BIAS = 8'd127;
    localparam logic [COUNT_W-1:0] MAX_REPEAT = 8'd128;

    // Size 0 is treated as one byte, and anything above four as four.
    function automatic logic [BPP_W-1:0] pixel_size(input logic [BPP_W-1:0] bpp);
        logic [BPP_W-1:0] size;
        if (bpp == 3'd0) begin
            size = 3'd1;
        end else if (bpp > 3'd4) begin
            size = 3'd4;
        end else begin
            size = bpp;
        end
        return size;
    endfunction

endpackage

>>> src/tga_rle_pixel_decoder_unit.sv
// ============================================================================
// TGA RLE pixel decoder
// Decodes a Truevision RLE pixel byte stream into (pixel, repeat) runs.
// ============================================================================
// The block takes one stream byte per clock while o_in_stall is low: each
// byte is captured in an input register and then fully decoded into a result
// register as soon as that register is empty or being drained, and the
// result stays valid there until the consumer takes it without a stall.
// Output stall backs up into the input stall in the same cycle, and a waiting
// result does not block the next byte while the result register is being
// drained. The pixel count target (width times height) is registered and is
// updated at the same edge as the configuration register that is written.
`include "tga_rle_pixel_decoder_unit_defines.svh"

module tga_rle_pixel_decoder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // APB-style configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tga_rle_pkg::ADDR_W-1:0]  paddr,
    input  logic [tga_rle_pkg::DATA_W-1:0]  pwdata,
    output logic [tga_rle_pkg::DATA_W-1:0]  prdata,
    output logic                            pready,
    // Byte input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_start_image,
    // Run output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [tga_rle_pkg::PIXEL_W-1:0] o_pixel_value,
    output logic [tga_rle_pkg::COUNT_W-1:0] o_repeat_count,
    output logic                            o_end_of_image,
    output logic                            o_overflow_error
);
    import tga_rle_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RAW,
        PH_RUN,
        PH_HALT
    } t_phase_e;

    // Configuration
    logic [BPP_W-1:0]   r_bpp;
    logic [DIM_W-1:0]   r_image_width;
    logic [DIM_W-1:0]   r_image_height;
    logic [PIXEL_W-1:0] r_total;
    logic [BPP_W-1:0]   n_bpp;
    logic [DIM_W-1:0]   n_image_width;
    logic [DIM_W-1:0]   n_image_height;

    // Input register
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_start;

    // Decoder state
    t_phase_e           r_phase;
    logic [7:0]         r_packet_remaining;
    logic [7:0]         r_run_length;
    logic [1:0]         r_byte_position;
    logic [PIXEL_W-1:0] r_pixel_assembly;
    logic [31:0]        r_pixels_done;

    // Result register
    logic               r_out_valid;
    logic [PIXEL_W-1:0] r_pixel_value;
    logic [COUNT_W-1:0] r_repeat_count;
    logic               r_end_of_image;
    logic               r_overflow_error;

    // Next-state values
    t_phase_e           n_phase;
    logic [7:0]         n_packet_remaining;
    logic [7:0]         n_run_length;
    logic [1:0]         n_byte_position;
    logic [PIXEL_W-1:0] n_pixel_assembly;
    logic [31:0]        n_pixels_done;
    logic               n_emit;
    logic [PIXEL_W-1:0] n_pixel_value;
    logic [COUNT_W-1:0] n_repeat_count;
    logic               n_end_of_image;
    logic               n_overflow_error;

    logic               advance;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            REG_BPP:    prdata = {{(DATA_W-BPP_W){1'b0}}, r_bpp};
            REG_WIDTH:  prdata = {{(DATA_W-DIM_W){1'b0}}, r_image_width};
            REG_HEIGHT: prdata = {{(DATA_W-DIM_W){1'b0}}, r_image_height};
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        n_bpp          = r_bpp;
        n_image_width  = r_image_width;
        n_image_height = r_image_height;
        if (cfg_write) begin
            case (paddr[3:2])
                REG_BPP:    n_bpp          = pwdata[BPP_W-1:0];
                REG_WIDTH:  n_image_width  = pwdata[DIM_W-1:0];
                REG_HEIGHT: n_image_height = pwdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // The byte held in the input register is decoded when the result register is
    // empty or being drained, whether or not the byte yields a result.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_comb begin
        t_phase_e           cur_phase;
        logic [7:0]         cur_remaining;
        logic [7:0]         cur_run;
        logic [1:0]         cur_position;
        logic [PIXEL_W-1:0] cur_assembly;
        logic [31:0]        cur_done;
        logic [PIXEL_W-1:0] assembled;
        logic [COUNT_W-1:0] count;
        logic [7:0]         remaining_next;
        logic [31:0]        fit;
        logic [COUNT_W-1:0] emitted;
        logic               ended;

        // A start-of-image byte restarts decoding from a clean state.
        if (r_in_start) begin
            cur_phase     = PH_HEADER;
            cur_remaining = '0;
            cur_run       = '0;
            cur_position  = '0;
            cur_assembly  = '0;
            cur_done      = '0;
        end else begin
            cur_phase     = r_phase;
            cur_remaining = r_packet_remaining;
            cur_run       = r_run_length;
            cur_position  = r_byte_position;
            cur_assembly  = r_pixel_assembly;
            cur_done      = r_pixels_done;
        end

        assembled = cur_assembly
                  | ({{(PIXEL_W-8){1'b0}}, r_in_byte} << {cur_position, 3'b000});
        count     = (cur_phase == PH_RUN) ? cur_run : 8'd1;
        remaining_next = ((cur_phase == PH_RUN) || (cur_remaining == 8'd0))
                       ? 8'd0 : cur_remaining - 8'd1;
        fit       = (cur_done >= r_total) ? 32'd0 : r_total - cur_done;
        emitted   = ({24'd0, count} < fit) ? count : fit[COUNT_W-1:0];
        ended     = ({24'd0, emitted} == fit);

        n_phase            = cur_phase;
        n_packet_remaining = cur_remaining;
        n_run_length       = cur_run;
        n_byte_position    = cur_position;
        n_pixel_assembly   = cur_assembly;
        n_pixels_done      = cur_done;
        n_emit             = 1'b0;
        n_pixel_value      = assembled;
        n_repeat_count     = emitted;
        n_end_of_image     = ended;
        n_overflow_error   = ({24'd0, count} > fit) || (ended && (remaining_next != 8'd0));

        case (cur_phase)
            PH_HEADER: begin
                if (r_in_byte < RUN_FLAG) begin
                    n_phase            = PH_RAW;
                    n_packet_remaining = r_in_byte + 8'd1;
                    n_run_length       = '0;
                end else begin
                    n_phase            = PH_RUN;
                    n_run_length       = r_in_byte - RUN_BIAS;
                    n_packet_remaining = 8'd1;
                end
                n_byte_position  = '0;
                n_pixel_assembly = '0;
            end
            PH_RAW, PH_RUN: begin
                if (({1'b0, cur_position} + 3'd1) < pixel_size(r_bpp)) begin
                    n_byte_position  = cur_position + 2'd1;
                    n_pixel_assembly = assembled;
                end else begin
                    n_emit             = 1'b1;
                    n_packet_remaining = remaining_next;
                    n_pixels_done      = cur_done + {24'd0, emitted};
                    n_byte_position    = '0;
                    n_pixel_assembly   = '0;
                    if (ended) begin
                        n_phase = PH_HALT;
                    end else if (remaining_next == 8'd0) begin
                        n_phase = PH_HEADER;
                    end
                end
            end
            default: begin
                // Image complete: bytes are dropped until the next start.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp              <= BPP_RESET;
            r_image_width      <= WIDTH_RESET;
            r_image_height     <= HEIGHT_RESET;
            r_total            <= 32'd1;
            r_in_valid         <= 1'b0;
            r_phase            <= PH_HEADER;
            r_packet_remaining <= '0;
            r_run_length       <= '0;
            r_byte_position    <= '0;
            r_pixel_assembly   <= '0;
            r_pixels_done      <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            r_bpp          <= n_bpp;
            r_image_width  <= n_image_width;
            r_image_height <= n_image_height;
            r_total        <= {{(PIXEL_W-DIM_W){1'b0}}, n_image_width}
                            * {{(PIXEL_W-DIM_W){1'b0}}, n_image_height};

            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
                r_in_byte  <= i_data_byte;
                r_in_start <= i_start_image;
            end

            if (advance) begin
                r_phase            <= n_phase;
                r_packet_remaining <= n_packet_remaining;
                r_run_length       <= n_run_length;
                r_byte_position    <= n_byte_position;
                r_pixel_assembly   <= n_pixel_assembly;
                r_pixels_done      <= n_pixels_done;
            end

            if (advance && n_emit) begin
                r_out_valid      <= 1'b1;
                r_pixel_value    <= n_pixel_value;
                r_repeat_count   <= n_repeat_count;
                r_end_of_image   <= n_end_of_image;
                r_overflow_error <= n_overflow_error;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pixel_value    = r_pixel_value;
    assign o_repeat_count   = r_repeat_count;
    assign o_end_of_image   = r_end_of_image;
    assign o_overflow_error = r_overflow_error;

    // An overflowing packet always closes the image.
    `TGA_ASSERT_IMPL(a_overflow_ends, i_clk, i_rst_n, o_out_valid && o_overflow_error, o_end_of_image)
    // A run never reports more copies than one packet can hold.
    `TGA_ASSERT_IMPL(a_repeat_bound, i_clk, i_rst_n, o_out_valid, o_repeat_count <= MAX_REPEAT)
    // The run that closes the image leaves the decoder halted.
    `TGA_ASSERT_NEXT(a_end_halts, i_clk, i_rst_n, advance && n_emit && n_end_of_image, r_phase == PH_HALT)
    // Input backpressure only arises from a blocked result register.
    `TGA_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid && i_out_stall)

endmodule

>>> sim/tga_rle_pixel_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// TGA RLE pixel decoder testbench
// Feeds RLE-coded pixel streams under random input gaps and output stalls,
// predicts every (pixel, repeat) run in the bench and compares each beat that
// leaves the decoder, field by field, against the oldest predicted run.
// ============================================================================
module tga_rle_pixel_decoder_unit_tb;
    import tga_rle_pkg::*;

    localparam int RANDOM_BYTES = 1100;
    localparam int IDLE_LIMIT   = 3000;

    typedef enum logic [1:0] {ST_HEADER, ST_RAW, ST_RUN, ST_DONE} t_decode_phase;

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic [COUNT_W-1:0] count;
        logic               eoi;
        logic               ovf;
    } t_pixel_run;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [7:0]          i_data_byte = '0;
    logic                i_start_image = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [PIXEL_W-1:0]  o_pixel_value;
    logic [COUNT_W-1:0]  o_repeat_count;
    logic                o_end_of_image;
    logic                o_overflow_error;

    // Bench copy of the decoder configuration and state.
    logic [2:0]          cfg_bpp = 3'd4;
    logic [15:0]         cfg_width = 16'd1;
    logic [15:0]         cfg_height = 16'd1;
    t_decode_phase       st_phase = ST_HEADER;
    logic [7:0]          pkt_left = '0;
    logic [7:0]          run_len = '0;
    logic [1:0]          byte_pos = '0;
    logic [31:0]         pix_acc = '0;
    logic [31:0]         pix_done = '0;

    t_pixel_run          pending_runs[$];
    t_pixel_run          oldest_run;
    int                  bytes_decoded = 0;
    int                  mismatch_count = 0;
    int                  idle_cycles = 0;
    logic                in_gap_mode = 1'b0;
    logic                out_stall_mode = 1'b0;
    int                  stall_left = 0;
    int                  stall_hold;

    tga_rle_pixel_decoder_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_start_image    (i_start_image),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pixel_value    (o_pixel_value),
        .o_repeat_count   (o_repeat_count),
        .o_end_of_image   (o_end_of_image),
        .o_overflow_error (o_overflow_error)
    );

    always #10 i_clk = ~i_clk;

    function automatic int px_bytes(input logic [2:0] bpp);
        if (bpp == 3'd0) return 1;
        if (bpp > 3'd4) return 4;
        return int'(bpp);
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap(input logic enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // Advances the bench decoder by one accepted byte and queues the run it
    // completes, if any. Returns 1 when the decoder ignores the byte.
    function automatic logic decode_byte(input logic [7:0] b, input logic first);
        t_pixel_run        r;
        longint unsigned   cnt;
        longint unsigned   total;
        longint unsigned   fit;
        longint unsigned   emitted;
        logic              done_now;
        if (first) begin
            st_phase = ST_HEADER;
            pkt_left = '0;
            run_len  = '0;
            byte_pos = '0;
            pix_acc  = '0;
            pix_done = '0;
        end
        if (st_phase == ST_HEADER) begin
            if (b < RUN_FLAG) begin
                st_phase = ST_RAW;
                pkt_left = b + 8'd1;
                run_len  = '0;
            end else begin
                st_phase = ST_RUN;
                run_len  = b - RUN_BIAS;
                pkt_left = 8'd1;
            end
            byte_pos = '0;
            pix_acc  = '0;
            return 1'b0;
        end
        if (st_phase == ST_DONE) return 1'b1;

        pix_acc = pix_acc | ({24'd0, b} << (8 * byte_pos));
        if (int'(byte_pos) + 1 < px_bytes(cfg_bpp)) begin
            byte_pos = byte_pos + 2'd1;
            return 1'b0;
        end

        cnt = (st_phase == ST_RUN) ? longint'(run_len) : 1;
        pkt_left = (st_phase == ST_RUN || pkt_left == 0) ? 8'd0 : pkt_left - 8'd1;
        total = cfg_width;
        total = total * cfg_height;
        fit = (pix_done >= total) ? 0 : total - pix_done;
        emitted = (cnt < fit) ? cnt : fit;
        done_now = (emitted == fit);
        r.pixel = pix_acc;
        r.count = emitted[7:0];
        r.eoi   = done_now;
        r.ovf   = (cnt > fit) || (done_now && pkt_left != 0);
        pending_runs.push_back(r);
        pix_done = pix_done + emitted[31:0];

        byte_pos = '0;
        pix_acc  = '0;
        if (done_now) begin
            st_phase = ST_DONE;
        end else if (pkt_left == 0) begin
            st_phase = ST_HEADER;
        end
        return 1'b0;
    endfunction

    // One byte beat on the input channel; predicts its result on acceptance.
    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = pick_gap(in_gap_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_start_image <= first;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        if (!decode_byte(b, first)) bytes_decoded++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_runs.size() != 0);
        // A trailing byte that yields no run may still be in the pipeline.
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_BPP: begin
                cfg_bpp = value[2:0];
            end
            REG_WIDTH: begin
                cfg_width = value[15:0];
            end
            default: begin
                cfg_height = value[15:0];
            end
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("register readback", value, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_format(input logic [2:0] bpp, input logic [15:0] w,
                              input logic [15:0] h);
        wait_idle();
        write_register(REG_BPP, {29'd0, bpp});
        write_register(REG_WIDTH, {16'd0, w});
        write_register(REG_HEIGHT, {16'd0, h});
        // The pixel target comes from a registered multiplier.
        repeat (2) @(posedge i_clk);
    endtask

    // Reset values, and decoding that starts without a start_image beat.
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
        repeat (4) send_byte(8'hFF, 1'b0);
    endtask

    // A run packet clipped to the image, then a raw packet that overruns it.
    task automatic test_overflow();
        set_format(3'd1, 16'd3, 16'd1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h04, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // A zero image width gives a zero repeat count on the first pixel.
    task automatic test_empty_image();
        set_format(3'd2, 16'd0, 16'd5);
        send_byte(8'h81, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);
    endtask

    // Odd pixel sizes, and an image shrunk below the pixels already done.
    task automatic test_mid_image_resize();
        set_format(3'd0, 16'hFFFF, 16'hFFFF);
        send_byte(8'h05, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        set_format(3'd6, 16'd1, 16'd1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
    endtask

    function automatic logic [15:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r == 2) return 16'($urandom_range(1, 65535));
        return 16'($urandom_range(1, 6));
    endfunction

    function automatic logic [2:0] pick_bpp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 3'd1;
        if (r < 6) return 3'd3;
        if (r < 8) return 3'd4;
        if (r == 8) return 3'd2;
        return 3'($urandom_range(0, 7));
    endfunction

    // One image of well-formed packets with random content. Now and then a
    // packet is cut short and the next image begins in its middle.
    task automatic random_image(input int stop_at);
        logic [7:0] hdr;
        logic       first;
        int         nbytes;
        int         cut;
        int         k;
        first = 1'b1;
        // The first packet carries start_image, so a finished image restarts.
        while ((first || st_phase != ST_DONE) && bytes_decoded < stop_at) begin
            if ($urandom_range(0, 99) < 55) begin
                k = $urandom_range(0, 99);
                if (k < 70) hdr = 8'($urandom_range(0, 3));
                else if (k < 90) hdr = 8'($urandom_range(4, 126));
                else hdr = 8'd127;
            end else begin
                hdr = 8'($urandom_range(128, 255));
            end
            send_byte(hdr, first);
            first = 1'b0;
            nbytes = ((hdr < RUN_FLAG) ? int'(hdr) + 1 : 1) * px_bytes(cfg_bpp);
            cut = ($urandom_range(0, 49) == 0) ? $urandom_range(0, nbytes - 1) : nbytes;
            for (k = 0; k < cut && st_phase != ST_DONE; k++) begin
                send_byte(8'($urandom), 1'b0);
            end
            if (cut != nbytes) return;
        end
        // Trailing bytes after a finished image are dropped by the decoder.
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic test_random_stream();
        int goal;
        int phase_end;
        goal = bytes_decoded + RANDOM_BYTES;
        while (bytes_decoded < goal) begin
            set_format(pick_bpp(), pick_dim(), pick_dim());
            in_gap_mode    = ($urandom_range(0, 3) != 0);
            out_stall_mode = ($urandom_range(0, 3) != 0);
            phase_end = bytes_decoded + $urandom_range(50, 150);
            while (bytes_decoded < phase_end) random_image(phase_end);
        end
    endtask

    // Output stall: stretches of ready cycles broken by random stalls.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
            stall_left  <= $urandom_range(0, 6);
        end else begin
            stall_hold = pick_gap(out_stall_mode);
            i_out_stall <= (stall_hold != 0);
            stall_left  <= (stall_hold != 0) ? stall_hold - 1 : 0;
        end
    end

    // Run checker and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_runs.size() == 0) begin
                $display("%0t: run beat with nothing expected, actual pixel %h count %0d",
                         $time, o_pixel_value, o_repeat_count);
                mismatch_count++;
            end else begin
                oldest_run = pending_runs.pop_front();
                check_field("pixel_value", oldest_run.pixel, o_pixel_value);
                check_field("repeat_count", {24'd0, oldest_run.count}, {24'd0, o_repeat_count});
                check_field("end_of_image", {31'd0, oldest_run.eoi}, {31'd0, o_end_of_image});
                check_field("overflow_error", {31'd0, oldest_run.ovf},
                            {31'd0, o_overflow_error});
            end
        end
        if (!i_rst_n || psel || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_overflow();
        test_empty_image();
        test_mid_image_resize();
        test_random_stream();
        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
